// File: rtl/rte_pkg.sv
`default_nettype none

package rte_pkg;

    // register width of the trap address and cause words
    localparam int XLEN     = 64;
    localparam int ST_W     = 64;
    localparam int IRQ_W    = 12;
    localparam int CAUSE_W  = 6;
    localparam int CODE_W   = 4;
    localparam int PRIV_W   = 2;
    localparam int CMD_W    = 2;
    localparam int APB_AW   = 6;
    localparam int APB_DW   = 64;
    localparam int REG_IX_W = 3;

    // commands
    localparam logic [CMD_W-1:0] CMD_RAISE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POLL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd2;

    // privilege levels
    localparam logic [PRIV_W-1:0] PRIV_U   = 2'd0;
    localparam logic [PRIV_W-1:0] PRIV_S   = 2'd1;
    localparam logic [PRIV_W-1:0] PRIV_RSV = 2'd2;
    localparam logic [PRIV_W-1:0] PRIV_M   = 2'd3;

    // configuration register indexes
    localparam logic [REG_IX_W-1:0] REG_MEDELEG = 3'd0;
    localparam logic [REG_IX_W-1:0] REG_MIDELEG = 3'd1;
    localparam logic [REG_IX_W-1:0] REG_MIE     = 3'd2;
    localparam logic [REG_IX_W-1:0] REG_MTVEC   = 3'd3;
    localparam logic [REG_IX_W-1:0] REG_STVEC   = 3'd4;

    // mstatus bit positions
    localparam int ST_SIE  = 1;
    localparam int ST_MIE  = 3;
    localparam int ST_SPIE = 5;
    localparam int ST_MPIE = 7;
    localparam int ST_SPP  = 8;
    localparam int ST_MPP  = 11;
    localparam int ST_SDT  = 24;
    localparam int ST_MDT  = 42;

    // interrupt groups and codes
    localparam logic [IRQ_W-1:0]  M_IRQS = 12'hAAA;
    localparam logic [IRQ_W-1:0]  S_IRQS = 12'h222;
    localparam logic [CODE_W-1:0] IRQ_MEI = 4'd11;
    localparam logic [CODE_W-1:0] IRQ_MSI = 4'd3;
    localparam logic [CODE_W-1:0] IRQ_MTI = 4'd7;
    localparam logic [CODE_W-1:0] IRQ_SEI = 4'd9;
    localparam logic [CODE_W-1:0] IRQ_SSI = 4'd1;
    localparam logic [CODE_W-1:0] IRQ_STI = 4'd5;

    localparam logic [CAUSE_W-1:0] DOUBLE_TRAP_CODE = 6'd16;
    localparam logic [1:0]         TVEC_VECTORED    = 2'd1;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [CAUSE_W-1:0] cause;
        logic [XLEN-1:0]    fault_value;
        logic [XLEN-1:0]    pc;
        logic [IRQ_W-1:0]   pending;
        logic [ST_W-1:0]    load_status;
        logic [PRIV_W-1:0]  load_priv;
    } t_in_item;

    typedef struct packed {
        logic               trap_taken;
        logic               critical_error;
        logic [PRIV_W-1:0]  privilege;
        logic [XLEN-1:0]    next_pc;
        logic [XLEN-1:0]    cause_written;
        logic [XLEN-1:0]    tval_written;
        logic [XLEN-1:0]    second_tval;
        logic [ST_W-1:0]    status;
    } t_out_item;

    typedef struct packed {
        logic [XLEN-1:0]  exc_delegation;
        logic [IRQ_W-1:0] irq_delegation;
        logic [IRQ_W-1:0] irq_enable;
        logic [XLEN-1:0]  m_vector;
        logic [XLEN-1:0]  s_vector;
    } t_cfg;

    typedef struct packed {
        logic [PRIV_W-1:0] priv;
        logic [ST_W-1:0]   status;
        logic [XLEN-1:0]   dbl_tval;
    } t_arch_state;

endpackage

`default_nettype wire

// File: rtl/rte_csr.sv
`default_nettype none

module rte_csr
    import rte_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    logic [XLEN-1:0]     r_medeleg;
    logic [IRQ_W-1:0]    r_mideleg;
    logic [IRQ_W-1:0]    r_mie;
    logic [XLEN-1:0]     r_mtvec;
    logic [XLEN-1:0]     r_stvec;
    logic                wr_en;
    logic [REG_IX_W-1:0] reg_ix;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign reg_ix = paddr[APB_AW-1:APB_AW-REG_IX_W];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_medeleg <= '0;
            r_mideleg <= '0;
            r_mie     <= '0;
            r_mtvec   <= '0;
            r_stvec   <= '0;
        end else if (wr_en) begin
            unique case (reg_ix)
                REG_MEDELEG: r_medeleg <= pwdata[XLEN-1:0];
                REG_MIDELEG: r_mideleg <= pwdata[IRQ_W-1:0];
                REG_MIE:     r_mie     <= pwdata[IRQ_W-1:0];
                REG_MTVEC:   r_mtvec   <= pwdata[XLEN-1:0];
                REG_STVEC:   r_stvec   <= pwdata[XLEN-1:0];
                default: begin
                end
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_ix)
            REG_MEDELEG: prdata = r_medeleg;
            REG_MIDELEG: prdata = {{(APB_DW-IRQ_W){1'b0}}, r_mideleg};
            REG_MIE:     prdata = {{(APB_DW-IRQ_W){1'b0}}, r_mie};
            REG_MTVEC:   prdata = r_mtvec;
            REG_STVEC:   prdata = r_stvec;
            default:     prdata = '0;
        endcase
    end

    assign o_cfg = '{exc_delegation: r_medeleg, irq_delegation: r_mideleg,
                     irq_enable: r_mie, m_vector: r_mtvec, s_vector: r_stvec};

endmodule

`default_nettype wire

// File: rtl/rte_core.sv
`default_nettype none

module rte_core
    import rte_pkg::*;
(
    input  t_in_item    i_item,
    input  t_cfg        i_cfg,
    input  t_arch_state i_state,
    output t_arch_state o_state,
    output t_out_item   o_res
);

    logic [IRQ_W-1:0]   irq_mask;
    logic [IRQ_W-1:0]   irq_ready;
    logic [CODE_W-1:0]  irq_code;
    logic               is_raise;
    logic               is_irq;
    logic               want_trap;
    logic               to_s_req;
    logic               dbl;
    logic               to_s;
    logic               crit;
    logic               entry;
    logic [XLEN-1:0]    tval_in;
    logic [XLEN-1:0]    xcause;
    logic [XLEN-1:0]    xtval;
    logic [XLEN-1:0]    tvec;
    logic [XLEN-1:0]    base;
    logic [XLEN-1:0]    handler;
    logic [ST_W-1:0]    st_entry;
    t_arch_state        nxt;

    assign is_raise = (i_item.command == CMD_RAISE);

    // interrupt enable mask by privilege and global enables
    always_comb begin
        unique case (i_state.priv)
            PRIV_M:  irq_mask = i_state.status[ST_MIE] ? (~i_cfg.irq_delegation & M_IRQS) : '0;
            PRIV_S:  irq_mask = (~i_cfg.irq_delegation & M_IRQS) |
                                (i_state.status[ST_SIE] ? (i_cfg.irq_delegation & S_IRQS) : '0);
            default: irq_mask = M_IRQS;
        endcase
    end

    assign irq_ready = i_item.pending & i_cfg.irq_enable & irq_mask;

    // fixed priority pick
    always_comb begin
        priority if (irq_ready[IRQ_MEI]) irq_code = IRQ_MEI;
        else if (irq_ready[IRQ_MSI])     irq_code = IRQ_MSI;
        else if (irq_ready[IRQ_MTI])     irq_code = IRQ_MTI;
        else if (irq_ready[IRQ_SEI])     irq_code = IRQ_SEI;
        else if (irq_ready[IRQ_SSI])     irq_code = IRQ_SSI;
        else                             irq_code = IRQ_STI;
    end

    assign is_irq    = (i_item.command == CMD_POLL) && (irq_ready != '0);
    assign want_trap = is_raise || is_irq;

    // delegation and double-trap resolution
    assign to_s_req = (i_state.priv != PRIV_M) &&
                      (is_raise ? i_cfg.exc_delegation[i_item.cause]
                                : i_cfg.irq_delegation[irq_code]);
    assign dbl   = to_s_req && i_state.status[ST_SDT];
    assign to_s  = to_s_req && !i_state.status[ST_SDT];
    assign crit  = want_trap && !to_s && i_state.status[ST_MDT];
    assign entry = want_trap && !crit;

    assign tval_in = is_raise ? i_item.fault_value : '0;

    // cause and tval written to the target mode
    always_comb begin
        if (dbl) begin
            xcause = {{(XLEN-CAUSE_W){1'b0}}, DOUBLE_TRAP_CODE};
            xtval  = '0;
        end else if (is_raise) begin
            xcause = {{(XLEN-CAUSE_W){1'b0}}, i_item.cause};
            xtval  = tval_in;
        end else begin
            xcause = {1'b1, {(XLEN-1-CODE_W){1'b0}}, irq_code};
            xtval  = '0;
        end
    end

    // status update on entry
    always_comb begin
        st_entry = i_state.status;
        if (to_s) begin
            st_entry[ST_SPP]  = (i_state.priv == PRIV_S);
            st_entry[ST_SPIE] = i_state.status[ST_SIE];
            st_entry[ST_SIE]  = 1'b0;
            st_entry[ST_SDT]  = 1'b1;
        end else begin
            st_entry[ST_MPP+1:ST_MPP] = i_state.priv;
            st_entry[ST_MPIE] = i_state.status[ST_MIE];
            st_entry[ST_MIE]  = 1'b0;
            st_entry[ST_MDT]  = 1'b1;
        end
    end

    // handler address
    assign tvec    = to_s ? i_cfg.s_vector : i_cfg.m_vector;
    assign base    = {tvec[XLEN-1:2], 2'b00};
    assign handler = (is_irq && !dbl && (tvec[1:0] == TVEC_VECTORED))
                     ? base + {{(XLEN-CODE_W-2){1'b0}}, irq_code, 2'b00}
                     : base;

    // next architectural state
    always_comb begin
        nxt = i_state;
        if (i_item.command == CMD_LOAD) begin
            nxt.status = i_item.load_status;
            if (i_item.load_priv != PRIV_RSV) begin
                nxt.priv = i_item.load_priv;
            end
        end else if (entry) begin
            nxt.status = st_entry;
            nxt.priv   = to_s ? PRIV_S : PRIV_M;
            if (dbl) begin
                nxt.dbl_tval = tval_in;
            end
        end
    end

    assign o_state = nxt;

    assign o_res = '{trap_taken:     want_trap,
                     critical_error: crit,
                     privilege:      nxt.priv,
                     next_pc:        entry ? handler : i_item.pc,
                     cause_written:  entry ? xcause : '0,
                     tval_written:   entry ? xtval : '0,
                     second_tval:    nxt.dbl_tval,
                     status:         nxt.status};

endmodule

`default_nettype wire

// File: rtl/riscv_trap_entry_unit.sv
`default_nettype none

// channel   direction  handshake                    payload
// input     in         i_in_valid / o_in_stall      i_in_item  (t_in_item)
// result    out        o_out_valid / i_out_stall    o_out_item (t_out_item)
// config    in         psel penable pwrite pready   paddr pwdata prdata
//
// one item per cycle while the result is not stalled; an item passes through
// the input register and then leaves through the result register. the trap
// state updates as the item moves to the result register, so the next item
// sees it. reset (synchronous) empties both registers and puts the hart in M
// mode with mstatus clear. a stalled result holds the input register, which
// then stalls the input channel.
module riscv_trap_entry_unit
    import rte_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  t_in_item               i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_item              o_out_item,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    t_cfg        cfg;
    t_arch_state r_state;
    t_arch_state n_state;
    t_in_item    r_in;
    logic        r_in_valid;
    t_out_item   r_out;
    t_out_item   n_out;
    logic        r_out_valid;
    logic        advance;
    logic        in_xfer;

    rte_csr u_csr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rte_core u_core (
        .i_item  (r_in),
        .i_cfg   (cfg),
        .i_state (r_state),
        .o_state (n_state),
        .o_res   (n_out)
    );

    // pipeline control
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_item;
        end
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.priv     <= PRIV_M;
            r_state.status   <= '0;
            r_state.dbl_tval <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire
